[rtl/core/fircb_pkg.sv]
`default_nettype none

package fircb_pkg;

    localparam int DATA_W    = 16;
    localparam int IDX_W     = 5;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    // per-cycle control into the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic en;
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_MAC   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

[rtl/core/fircb_mac.sv]
`default_nettype none

module fircb_mac #(
    parameter int ACC_W = 37
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire fircb_pkg::mac_ctrl_t               ctrl,
    input  wire logic signed [fircb_pkg::DATA_W-1:0] a,
    input  wire logic signed [fircb_pkg::DATA_W-1:0] b,
    output logic                                    busy,
    output logic signed [fircb_pkg::DATA_W-1:0]     result,
    output logic                                    saturated
);
    import fircb_pkg::*;

    localparam int RW = ACC_W - 15;
    localparam logic signed [RW-1:0] R_MAX = RW'(32767);
    localparam logic signed [RW-1:0] R_MIN = -RW'(32768);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(16384);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_en_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  biased;
    logic signed [RW-1:0]     rounded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_en_reg <= 1'b0;
        end
        else
        begin
            prod_en_reg <= ctrl.en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_en_reg)
        begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    assign busy = ctrl.en | prod_en_reg;

    // round half up to q1.15, then clip
    assign biased  = acc_reg + HALF;
    assign rounded = biased[ACC_W-1:15];

    always_comb
    begin
        saturated = 1'b0;
        result    = rounded[DATA_W-1:0];
        if (rounded > R_MAX)
        begin
            result    = 16'sh7fff;
            saturated = 1'b1;
        end
        else if (rounded < R_MIN)
        begin
            result    = 16'sh8000;
            saturated = 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fir_filter_circular_buffer_core.sv]
// sample transaction: a sweep over all taps, then the result once the output is free
// coefficient load: no result; ready again in the next cycle
// one sample at a time, set by the single shared multiplier
// reset: asynchronous, active low; then a pass over every slot zeroes ring and
// coefficients with ready low
`default_nettype none

module fir_filter_circular_buffer_core #(
    parameter int TAPS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [15:0] sample, [20:16] coef_index, [36:21] coef_value, [39:37] zero
    input  wire logic [fircb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] func
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [15:0] result
    output logic [fircb_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // [0] saturated
    output logic                                   m_axis_tuser
);
    import fircb_pkg::*;

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W = PROD_W + AW;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    state_t state_reg, state_next;

    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] tap_reg, tap_next;
    logic          rd_en_reg;
    logic          m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg;
    logic          m_sat_reg;

    logic signed [DATA_W-1:0] ring_mem [TAPS];
    logic signed [DATA_W-1:0] coef_mem [TAPS];
    logic signed [DATA_W-1:0] ring_q;
    logic signed [DATA_W-1:0] coef_q;

    logic                     accept;
    logic                     func;
    logic signed [DATA_W-1:0] sample;
    logic [IDX_W-1:0]         coef_index;
    logic signed [DATA_W-1:0] coef_value;

    logic                     ring_we, coef_we;
    logic [AW-1:0]            ring_wa, coef_wa;
    logic signed [DATA_W-1:0] ring_wd, coef_wd;

    mac_ctrl_t                mac_ctrl;
    logic                     mac_busy;
    logic signed [DATA_W-1:0] mac_result;
    logic                     mac_sat;
    logic                     out_free;

    assign func       = s_axis_tuser;
    assign sample     = s_axis_tdata[15:0];
    assign coef_index = s_axis_tdata[20:16];
    assign coef_value = s_axis_tdata[36:21];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign ring_we = (state_reg == ST_CLEAR) || (accept && func == FUNC_SAMPLE);
    assign ring_wa = (state_reg == ST_CLEAR) ? tap_reg : wr_reg;
    assign ring_wd = (state_reg == ST_CLEAR) ? '0 : sample;

    assign coef_we = (state_reg == ST_CLEAR)
                  || (accept && func == FUNC_LOAD && int'(coef_index) < TAPS);
    assign coef_wa = (state_reg == ST_CLEAR) ? tap_reg : AW'(coef_index);
    assign coef_wd = (state_reg == ST_CLEAR) ? '0 : coef_value;

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wa] <= ring_wd;
        end
        ring_q <= ring_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_wa] <= coef_wd;
        end
        coef_q <= coef_mem[tap_reg];
    end

    always_comb
    begin
        state_next   = state_reg;
        wr_next      = wr_reg;
        pos_next     = pos_reg;
        tap_next     = tap_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        mac_ctrl     = '{clear: 1'b0, en: rd_en_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                tap_next = tap_reg + AW'(1);
                if (tap_reg == LAST)
                begin
                    tap_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && func == FUNC_SAMPLE)
                begin
                    // newest sample sits at the slot just written
                    pos_next       = wr_reg;
                    tap_next       = '0;
                    wr_next        = (wr_reg == LAST) ? '0 : wr_reg + AW'(1);
                    mac_ctrl.clear = 1'b1;
                    state_next     = ST_MAC;
                end
            end
            ST_MAC:
            begin
                pos_next = (pos_reg == '0) ? LAST : pos_reg - AW'(1);
                tap_next = tap_reg + AW'(1);
                if (tap_reg == LAST)
                begin
                    tap_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait for the pipeline to drain and the output register to free up
                if (!rd_en_reg && !mac_busy && out_free)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            wr_reg      <= '0;
            pos_reg     <= '0;
            tap_reg     <= '0;
            rd_en_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_reg      <= wr_next;
            pos_reg     <= pos_next;
            tap_reg     <= tap_next;
            rd_en_reg   <= (state_reg == ST_MAC);
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && !rd_en_reg && !mac_busy && out_free)
        begin
            m_data_reg <= mac_result;
            m_sat_reg  <= mac_sat;
        end
    end

    fircb_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .a         (ring_q),
        .b         (coef_q),
        .busy      (mac_busy),
        .result    (mac_result),
        .saturated (mac_sat)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_sat_reg;

endmodule

`default_nettype wire

[rtl/core/fircb_checker.sv]
`default_nettype none

module fircb_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [fircb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input wire logic                              m_axis_tuser
);
    import fircb_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // a sample transaction keeps the block busy for the tap sweep
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_SAMPLE
        |=> !s_axis_tready)
        else $error("ready after sample transaction");

    // after a coefficient load the block is ready again in the next cycle
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_LOAD
        |=> s_axis_tready)
        else $error("not ready after coefficient load");

    // a clipped result sits on a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser
        |-> m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000)
        else $error("saturated flag off the rails");

    // results only come out of the busy phase
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind fir_filter_circular_buffer_core fircb_checker u_fircb_checker (.*);

`default_nettype wire
